@@ hw/rtl/rlgbe_pkg.sv @@
// Shared types, constants and the gamma table of the LED bit encoder.
`default_nettype none

package rlgbe_pkg;

    // Field widths of the pixel and symbol words.
    localparam int INDEX_W   = 16;
    localparam int COLOR_W   = 24;
    localparam int CHAN_W    = 8;
    localparam int CODE_W    = 8;
    localparam int SLOT_W    = 5;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    // Symbols per pixel, green MSB first and blue LSB last.
    localparam int BITS_PER_PIXEL = 24;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BITS_PER_PIXEL - 1);

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Register reset values.
    localparam logic [CHAN_W-1:0]  BRIGHTNESS_RST = 8'd255;
    localparam logic [CODE_W-1:0]  ONE_CODE_RST   = 8'd248;
    localparam logic [CODE_W-1:0]  ZERO_CODE_RST  = 8'd192;
    localparam logic [INDEX_W-1:0] STRIP_LEN_RST  = 16'd64;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BRIGHTNESS = 8'd0,
        CFG_ONE_CODE   = 8'd1,
        CFG_ZERO_CODE  = 8'd2,
        CFG_STRIP_LEN  = 8'd3
    } t_cfg_reg;

    // Current register values as seen by the datapath.
    typedef struct packed {
        logic [CHAN_W-1:0]  brightness;
        logic [CODE_W-1:0]  one_code;
        logic [CODE_W-1:0]  zero_code;
        logic [INDEX_W-1:0] strip_len;
    } t_cfg;

    // One corrected pixel waiting for serialization.
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [COLOR_W-1:0] word;
    } t_entry;

    // Gamma 2.8 curve, entry i = round(255 * (i/255)^2.8).
    localparam logic [CHAN_W-1:0] GAMMA_ROM [256] = '{
        8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,
        8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd1,8'd1,8'd1,8'd1,
        8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,
        8'd2,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd4,8'd4,8'd4,8'd4,8'd4,8'd5,8'd5,8'd5,
        8'd5,8'd6,8'd6,8'd6,8'd6,8'd7,8'd7,8'd7,8'd7,8'd8,8'd8,8'd8,8'd9,8'd9,8'd9,8'd10,
        8'd10,8'd10,8'd11,8'd11,8'd11,8'd12,8'd12,8'd13,
        8'd13,8'd13,8'd14,8'd14,8'd15,8'd15,8'd16,8'd16,
        8'd17,8'd17,8'd18,8'd18,8'd19,8'd19,8'd20,8'd20,
        8'd21,8'd21,8'd22,8'd22,8'd23,8'd24,8'd24,8'd25,
        8'd25,8'd26,8'd27,8'd27,8'd28,8'd29,8'd29,8'd30,
        8'd31,8'd32,8'd32,8'd33,8'd34,8'd35,8'd35,8'd36,
        8'd37,8'd38,8'd39,8'd39,8'd40,8'd41,8'd42,8'd43,
        8'd44,8'd45,8'd46,8'd47,8'd48,8'd49,8'd50,8'd50,
        8'd51,8'd52,8'd54,8'd55,8'd56,8'd57,8'd58,8'd59,
        8'd60,8'd61,8'd62,8'd63,8'd64,8'd66,8'd67,8'd68,
        8'd69,8'd70,8'd72,8'd73,8'd74,8'd75,8'd77,8'd78,
        8'd79,8'd81,8'd82,8'd83,8'd85,8'd86,8'd87,8'd89,
        8'd90,8'd92,8'd93,8'd95,8'd96,8'd98,8'd99,8'd101,
        8'd102,8'd104,8'd105,8'd107,8'd109,8'd110,8'd112,8'd114,
        8'd115,8'd117,8'd119,8'd120,8'd122,8'd124,8'd126,8'd127,
        8'd129,8'd131,8'd133,8'd135,8'd137,8'd138,8'd140,8'd142,
        8'd144,8'd146,8'd148,8'd150,8'd152,8'd154,8'd156,8'd158,
        8'd160,8'd162,8'd164,8'd167,8'd169,8'd171,8'd173,8'd175,
        8'd177,8'd180,8'd182,8'd184,8'd186,8'd189,8'd191,8'd193,
        8'd196,8'd198,8'd200,8'd203,8'd205,8'd208,8'd210,8'd212,
        8'd215,8'd217,8'd220,8'd223,8'd225,8'd228,8'd231,8'd233,
        8'd236,8'd239,8'd241,8'd244,8'd247,8'd249,8'd252,8'd255
    };

endpackage

`default_nettype wire

@@ hw/rtl/rlgbe_if.sv @@
// Handshake interfaces for the pixel, symbol and configuration channels.
`default_nettype none

// Pixel write channel.
interface rlgbe_pix_if import rlgbe_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] pixel_index;
    logic [COLOR_W-1:0] pixel_color;

    modport source (output valid, output pixel_index, output pixel_color, input ready);
    modport sink   (input valid, input pixel_index, input pixel_color, output ready);
endinterface

// Code symbol channel.
interface rlgbe_sym_if import rlgbe_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] out_index;
    logic [SLOT_W-1:0]  bit_slot;
    logic [CODE_W-1:0]  code_symbol;
    logic               last_of_pixel;

    modport source (output valid, output out_index, output bit_slot, output code_symbol,
                    output last_of_pixel, input ready);
    modport sink   (input valid, input out_index, input bit_slot, input code_symbol,
                    input last_of_pixel, output ready);
endinterface

// Register write channel.
interface rlgbe_cfg_if import rlgbe_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rgb_led_gamma_bit_encoder.sv @@
// Top level of the RGB LED gamma bit encoder.
// Each accepted pixel word whose index is below the configured strip length is scaled
// by brightness, gamma-corrected and sent as 24 code symbols (green, red, blue, MSB
// first), one symbol per clock while the sink is ready; words with an index at or above
// it are taken and dropped. The serializer sets the rate, with no gap between pixels
// while the sink is ready. From acceptance, a word passes through the front-end stage
// register, the queue and the serializer's shift and output registers. The front end
// keeps taking words while the serializer works, until its stage and the queue are full.
// Configuration writes are taken in any cycle and should be made while idle.
`default_nettype none

module rgb_led_gamma_bit_encoder import rlgbe_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire i_clk,
    input  wire i_rst_n,
    rlgbe_cfg_if.sink   i_cfg,
    rlgbe_pix_if.sink   i_pix,
    rlgbe_sym_if.source o_sym
);

    t_cfg   cfg;
    logic   q_ready;
    logic   q_push;
    t_entry q_in;
    logic   q_valid;
    logic   q_pop;
    t_entry q_out;

    // Register file.
    rlgbe_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Range check, scaling and gamma.
    rlgbe_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (i_pix),
        .i_cfg     (cfg),
        .i_q_ready (q_ready),
        .o_push    (q_push),
        .o_entry   (q_in)
    );

    // Decoupling queue.
    rlgbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_out)
    );

    // Symbol serializer.
    rlgbe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_entry (q_out),
        .o_pop     (q_pop),
        .o_sym     (o_sym)
    );

endmodule

`default_nettype wire

@@ hw/rtl/rlgbe_cfg.sv @@
// Configuration register file of the LED bit encoder.
`default_nettype none

module rlgbe_cfg import rlgbe_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    rlgbe_cfg_if.sink i_cfg,
    output t_cfg o_cfg
);

    t_cfg r_cfg;

    // Writes are always taken; unknown indexes are ignored.
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness <= BRIGHTNESS_RST;
            r_cfg.one_code   <= ONE_CODE_RST;
            r_cfg.zero_code  <= ZERO_CODE_RST;
            r_cfg.strip_len  <= STRIP_LEN_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_BRIGHTNESS: r_cfg.brightness <= i_cfg.data[CHAN_W-1:0];
                CFG_ONE_CODE:   r_cfg.one_code   <= i_cfg.data[CODE_W-1:0];
                CFG_ZERO_CODE:  r_cfg.zero_code  <= i_cfg.data[CODE_W-1:0];
                CFG_STRIP_LEN:  r_cfg.strip_len  <= i_cfg.data[INDEX_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rlgbe_front.sv @@
// Front end: accepts pixel words, drops out-of-range indexes, scales and gamma-corrects.
`default_nettype none

module rlgbe_front import rlgbe_pkg::*; (
    input  wire    i_clk,
    input  wire    i_rst_n,
    rlgbe_pix_if.sink i_pix,
    input  t_cfg   i_cfg,
    input  wire    i_q_ready,
    output logic   o_push,
    output t_entry o_entry
);

    logic               r_valid;
    logic [INDEX_W-1:0] r_index;
    logic [CHAN_W-1:0]  r_scaled [3];

    logic               accept;
    logic               keep;
    logic [2*CHAN_W-1:0] prod [3];

    // The stage frees when its word moves into the queue.
    assign i_pix.ready = !r_valid || i_q_ready;
    assign accept      = i_pix.valid && i_pix.ready;
    assign keep        = accept && (i_pix.pixel_index < i_cfg.strip_len);

    // Brightness scaling per channel: 0 red, 1 green, 2 blue.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c] = i_pix.pixel_color[(2-c)*CHAN_W +: CHAN_W] * i_cfg.brightness;
        end
    end

    // Scaled channel register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= keep || (r_valid && !i_q_ready);
        end
        if (keep) begin
            r_index <= i_pix.pixel_index;
            for (int c = 0; c < 3; c++) begin
                r_scaled[c] <= prod[c][2*CHAN_W-1:CHAN_W];
            end
        end
    end

    // Gamma lookup and packing in green, red, blue order.
    assign o_push        = r_valid && i_q_ready;
    assign o_entry.index = r_index;
    assign o_entry.word  = {GAMMA_ROM[r_scaled[1]], GAMMA_ROM[r_scaled[0]],
                            GAMMA_ROM[r_scaled[2]]};

endmodule

`default_nettype wire

@@ hw/rtl/rlgbe_queue.sv @@
// Short queue of corrected pixels between the front end and the serializer.
`default_nettype none

module rlgbe_queue import rlgbe_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_push,
    input  t_entry i_entry,
    output logic   o_ready,
    input  wire    i_pop,
    output logic   o_valid,
    output t_entry o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    // Pointer wrap at the queue depth.
    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rlgbe_back.sv @@
// Back end: shifts each corrected pixel out as 24 code symbols through an output register.
`default_nettype none

module rlgbe_back import rlgbe_pkg::*; (
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  t_cfg   i_cfg,
    input  wire    i_q_valid,
    input  t_entry i_q_entry,
    output logic   o_pop,
    rlgbe_sym_if.source o_sym
);

    logic                      r_busy;
    logic [INDEX_W-1:0]        r_index;
    logic [BITS_PER_PIXEL-1:0] r_word;
    logic [SLOT_W-1:0]         r_slot;

    logic                      r_out_valid;
    logic [INDEX_W-1:0]        r_out_index;
    logic [SLOT_W-1:0]         r_out_slot;
    logic [CODE_W-1:0]         r_out_code;
    logic                      r_out_last;

    logic                      advance;
    logic                      at_last;

    // One symbol leaves per cycle whenever the output register can take it.
    assign advance = r_busy && (!r_out_valid || o_sym.ready);
    assign at_last = (r_slot == LAST_SLOT);
    assign o_pop   = i_q_valid && (!r_busy || (advance && at_last));

    assign o_sym.valid         = r_out_valid;
    assign o_sym.out_index     = r_out_index;
    assign o_sym.bit_slot      = r_out_slot;
    assign o_sym.code_symbol   = r_out_code;
    assign o_sym.last_of_pixel = r_out_last;

    // Shift register and slot counter of the pixel in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (advance && at_last) begin
            r_busy <= 1'b0;
        end
        if (o_pop) begin
            r_index <= i_q_entry.index;
            r_word  <= i_q_entry.word;
            r_slot  <= '0;
        end else if (advance) begin
            r_word <= {r_word[BITS_PER_PIXEL-2:0], 1'b0};
            r_slot <= r_slot + 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_sym.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_index <= r_index;
            r_out_slot  <= r_slot;
            r_out_code  <= r_word[BITS_PER_PIXEL-1] ? i_cfg.one_code : i_cfg.zero_code;
            r_out_last  <= at_last;
        end
    end

    // The last flag marks exactly the final slot of a pixel.
    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_last == (r_out_slot == LAST_SLOT)))
        else $error("last flag does not match the final slot");

    // A pixel stays in flight until its final symbol is sent.
    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !at_last) |=> r_busy)
        else $error("pixel dropped before its final symbol");

    // A new pixel is taken only when the previous one is finished.
    a_pop_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_busy) |-> (advance && at_last))
        else $error("pixel loaded over one in flight");

    // Consecutive symbols of one pixel count up by one.
    a_slot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !at_last) |=> (r_slot == $past(r_slot) + 1'b1))
        else $error("slot counter skipped");

endmodule

`default_nettype wire

@@ bench/rlgbe_symbol_checker.sv @@
// Passive checker that predicts and compares the code words of the LED bit encoder.
`timescale 1ns / 1ps

module rlgbe_symbol_checker import rlgbe_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    rlgbe_cfg_if i_cfg,
    rlgbe_pix_if i_pix,
    rlgbe_sym_if i_sym,
    output int   o_errors,
    output int   o_pending
);

    // One expected code word on the symbol channel.
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [SLOT_W-1:0]  slot;
        logic [CODE_W-1:0]  code;
        logic               last;
    } t_code_word;

    // Gamma 2.8 curve, kept here as an independent copy of the table.
    localparam logic [CHAN_W-1:0] gamma_curve [256] = '{
        0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,
        0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  1,  1,  1,  1,
        1,  1,  1,  1,  1,  1,  1,  1,  1,  2,  2,  2,  2,  2,  2,  2,
        2,  3,  3,  3,  3,  3,  3,  3,  4,  4,  4,  4,  4,  5,  5,  5,
        5,  6,  6,  6,  6,  7,  7,  7,  7,  8,  8,  8,  9,  9,  9, 10,
       10, 10, 11, 11, 11, 12, 12, 13, 13, 13, 14, 14, 15, 15, 16, 16,
       17, 17, 18, 18, 19, 19, 20, 20, 21, 21, 22, 22, 23, 24, 24, 25,
       25, 26, 27, 27, 28, 29, 29, 30, 31, 32, 32, 33, 34, 35, 35, 36,
       37, 38, 39, 39, 40, 41, 42, 43, 44, 45, 46, 47, 48, 49, 50, 50,
       51, 52, 54, 55, 56, 57, 58, 59, 60, 61, 62, 63, 64, 66, 67, 68,
       69, 70, 72, 73, 74, 75, 77, 78, 79, 81, 82, 83, 85, 86, 87, 89,
       90, 92, 93, 95, 96, 98, 99,101,102,104,105,107,109,110,112,114,
      115,117,119,120,122,124,126,127,129,131,133,135,137,138,140,142,
      144,146,148,150,152,154,156,158,160,162,164,167,169,171,173,175,
      177,180,182,184,186,189,191,193,196,198,200,203,205,208,210,212,
      215,217,220,223,225,228,231,233,236,239,241,244,247,249,252,255
    };

    t_cfg       regs_now;
    t_code_word symbols_due [$];
    int         err_count = 0;

    assign o_errors = err_count;

    // Scale one channel by the brightness and look it up on the curve.
    function automatic logic [CHAN_W-1:0] dimmed_gamma(input logic [CHAN_W-1:0] chan,
                                                       input logic [CHAN_W-1:0] gain);
        logic [2*CHAN_W-1:0] product;
        product = chan * gain;
        return gamma_curve[product[2*CHAN_W-1:CHAN_W]];
    endfunction

    // Corrected color in transmit order: green, red, blue.
    function automatic logic [COLOR_W-1:0] corrected_grb(input logic [COLOR_W-1:0] color,
                                                         input logic [CHAN_W-1:0] gain);
        return {dimmed_gamma(color[15:8], gain), dimmed_gamma(color[23:16], gain),
                dimmed_gamma(color[7:0], gain)};
    endfunction

    // Report one field of a code word that does not match.
    task automatic check_field(input string name, input t_code_word due,
                               input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: pixel %0d slot %0d %s expected %0h, actual %0h",
                     $time, due.index, due.slot, name, want, got);
            err_count++;
        end
    endtask

    // Track register writes, expand accepted pixels and compare code words.
    always @(posedge i_clk) begin : monitor
        t_code_word         due;
        logic [COLOR_W-1:0] grb;
        if (!i_rst_n) begin
            regs_now = '{BRIGHTNESS_RST, ONE_CODE_RST, ZERO_CODE_RST, STRIP_LEN_RST};
            symbols_due.delete();
        end else begin
            if (i_sym.valid && i_sym.ready) begin
                if (symbols_due.size() == 0) begin
                    $display("%0t: unexpected code word, expected none, actual index %0d slot %0d",
                             $time, i_sym.out_index, i_sym.bit_slot);
                    err_count++;
                end else begin
                    due = symbols_due.pop_front();
                    check_field("out_index", due, 32'(due.index), 32'(i_sym.out_index));
                    check_field("bit_slot", due, 32'(due.slot), 32'(i_sym.bit_slot));
                    check_field("code_symbol", due, 32'(due.code), 32'(i_sym.code_symbol));
                    check_field("last_of_pixel", due, 32'(due.last), 32'(i_sym.last_of_pixel));
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_BRIGHTNESS: regs_now.brightness = i_cfg.data[CHAN_W-1:0];
                    CFG_ONE_CODE:   regs_now.one_code   = i_cfg.data[CODE_W-1:0];
                    CFG_ZERO_CODE:  regs_now.zero_code  = i_cfg.data[CODE_W-1:0];
                    CFG_STRIP_LEN:  regs_now.strip_len  = i_cfg.data[INDEX_W-1:0];
                    default: ;
                endcase
            end
            // Pixels at or past the strip length are dropped silently.
            if (i_pix.valid && i_pix.ready && i_pix.pixel_index < regs_now.strip_len) begin
                grb = corrected_grb(i_pix.pixel_color, regs_now.brightness);
                for (int k = 0; k < BITS_PER_PIXEL; k++) begin
                    due.index = i_pix.pixel_index;
                    due.slot  = SLOT_W'(k);
                    due.code  = grb[BITS_PER_PIXEL-1-k] ? regs_now.one_code : regs_now.zero_code;
                    due.last  = (k == BITS_PER_PIXEL - 1);
                    symbols_due.push_back(due);
                end
            end
        end
        o_pending <= symbols_due.size();
    end

endmodule

@@ bench/rgb_led_gamma_bit_encoder_tb.sv @@
// Testbench top: clock, reset, pixel and register stimulus, and the final verdict.
`timescale 1ns / 1ps

module rgb_led_gamma_bit_encoder_tb;
    import rlgbe_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 2;
    localparam int DRAIN_PAUSE   = 8;
    localparam int END_PAUSE     = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_PIXELS  = 28;
    localparam int TIMEOUT_NS    = 10_000_000;

    // Register indexes that map to no register.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 8'd255;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic quiet = 1'b0;
    logic hold_req = 1'b0;
    int   src_calm = 0;
    int   errors;
    int   pending;

    rlgbe_cfg_if cfg_bus ();
    rlgbe_pix_if pix_bus ();
    rlgbe_sym_if sym_bus ();

    rgb_led_gamma_bit_encoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (pix_bus),
        .o_sym   (sym_bus)
    );

    rlgbe_symbol_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg_bus),
        .i_pix     (pix_bus),
        .i_sym     (sym_bus),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // Free-running clock.
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Hard limit on the run time.
    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Symbol sink pacing: random stall bursts, calm stretches and one long hold-off.
    initial begin : sym_pacing
        int stall_left;
        int calm_left;
        int hold_left;
        bit hold_taken;
        stall_left = 0;
        calm_left  = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        sym_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                sym_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                sym_bus.ready <= 1'b0;
            end else if (quiet || calm_left > 0) begin
                if (calm_left > 0) calm_left--;
                sym_bus.ready <= 1'b1;
            end else if ($urandom_range(0, 15) == 0) begin
                calm_left = $urandom_range(40, 160);
                sym_bus.ready <= 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                sym_bus.ready <= 1'b0;
            end else begin
                sym_bus.ready <= 1'b1;
            end
        end
    end

    // Offer one pixel word, possibly after a random gap, and wait until it is taken.
    task automatic send_pixel(input logic [INDEX_W-1:0] idx, input logic [COLOR_W-1:0] color);
        int gap;
        gap = 0;
        if (!quiet) begin
            if (src_calm > 0) begin
                src_calm--;
            end else if ($urandom_range(0, 15) == 0) begin
                src_calm = $urandom_range(10, 40);
            end else if ($urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 12);
            end
        end
        if (gap > 0) begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_bus.valid       <= 1'b1;
        pix_bus.pixel_index <= idx;
        pix_bus.pixel_color <= color;
        do @(posedge i_clk); while (pix_bus.ready !== 1'b1);
    endtask

    // Stop offering pixels and wait until every expected word has come out.
    task automatic wait_idle();
        pix_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    // One register write word; the caller lowers valid after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
    endtask

    task automatic program_regs(input logic [CFG_DAT_W-1:0] gain, input logic [CFG_DAT_W-1:0] one,
                                input logic [CFG_DAT_W-1:0] zero,
                                input logic [CFG_DAT_W-1:0] count);
        wait_idle();
        write_reg(CFG_BRIGHTNESS, gain);
        write_reg(CFG_ONE_CODE, one);
        write_reg(CFG_ZERO_CODE, zero);
        write_reg(CFG_STRIP_LEN, count);
        cfg_bus.valid <= 1'b0;
    endtask

    // Pick one color channel, leaning toward the extremes.
    function automatic logic [CHAN_W-1:0] rand_channel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int                 count;
        logic [INDEX_W-1:0] idx;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.index       <= '0;
        cfg_bus.data        <= '0;
        pix_bus.valid       <= 1'b0;
        pix_bus.pixel_index <= '0;
        pix_bus.pixel_color <= '0;
        i_rst_n             <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        // Reset settings: color extremes, last valid index and dropped indices.
        send_pixel(16'd0, 24'h000000);
        send_pixel(16'd63, 24'hFFFFFF);
        send_pixel(16'd64, 24'h123456);
        send_pixel(16'hFFFF, 24'hFFFFFF);
        send_pixel(16'd1, 24'hFF0000);
        send_pixel(16'd2, 24'h00FF00);
        send_pixel(16'd3, 24'h0000FF);
        send_pixel(16'd10, 24'h808080);

        // Zero brightness, all-ones and all-zeros codes, longest strip.
        program_regs(16'h0000, 16'h00FF, 16'h0000, 16'hFFFF);
        send_pixel(16'hFFFE, 24'hFFFFFF);
        send_pixel(16'hFFFF, 24'hFFFFFF);
        send_pixel(16'd0, 24'hAAAAAA);

        // Half brightness, values wider than their registers, a single LED.
        program_regs(16'h7F80, 16'hA55A, 16'h3C3C, 16'h0001);
        send_pixel(16'd0, 24'hFFFFFF);
        send_pixel(16'd1, 24'hFFFFFF);
        send_pixel(16'd0, 24'h7F80FF);

        // Empty strip, then writes to unmapped indexes that must change nothing.
        wait_idle();
        write_reg(CFG_STRIP_LEN, 16'h0000);
        write_reg(CFG_UNMAPPED_LO, 16'hFFFF);
        write_reg(CFG_UNMAPPED_HI, 16'hFFFF);
        cfg_bus.valid <= 1'b0;
        send_pixel(16'd0, 24'hFFFFFF);
        send_pixel(16'hFFFF, 24'h000000);

        // Random settings per phase; mostly in-range pixels with some dropped ones.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0:       count = 1;
                1:       count = 65535;
                2:       count = $urandom_range(2, 40);
                default: count = $urandom_range(1, 65535);
            endcase
            if (phase == RANDOM_PHASES - 1) quiet <= 1'b1;
            program_regs({CHAN_W'($urandom), rand_channel()}, CFG_DAT_W'($urandom),
                         CFG_DAT_W'($urandom), CFG_DAT_W'(count));
            if (phase == 1) hold_req <= 1'b1;
            for (int n = 0; n < PHASE_PIXELS; n++) begin
                if ($urandom_range(0, 9) < 8) begin
                    idx = INDEX_W'($urandom_range(0, count - 1));
                end else begin
                    idx = INDEX_W'($urandom);
                end
                send_pixel(idx, {rand_channel(), rand_channel(), rand_channel()});
            end
        end

        // Drain, give stray words time to show up, then decide.
        wait_idle();
        repeat (END_PAUSE) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
